[design/ilt_pkg.sv]
// -----------------------------------------------------------------------------
// ilt_pkg - shared constants for the integer list table
// Action codes, status codes and field widths used by the table and its RAM.
// -----------------------------------------------------------------------------
`default_nettype none

package ilt_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;
	localparam int ACT_W        = 3;
	localparam int STAT_W       = 2;
	localparam int FLD_W        = 7;

	localparam logic [ACT_W-1:0] ACT_LOOKUP   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ADD_UNIQ = 3'd1;
	localparam logic [ACT_W-1:0] ACT_ADD      = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_REPLACE  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd5;

	localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

	// first_index code for "no match"
	localparam logic [FLD_W-1:0] IDX_NONE = 7'h7F;

endpackage

`default_nettype wire

[design/ilt_ram.sv]
// -----------------------------------------------------------------------------
// ilt_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// -----------------------------------------------------------------------------
`default_nettype none

module ilt_ram #(
	parameter int WIDTH = ilt_pkg::DATA_W,
	parameter int DEPTH = ilt_pkg::CAPACITY_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[design/integer_list_table.sv]
// -----------------------------------------------------------------------------
// integer_list_table - insertion-ordered list of signed 32-bit values
// Lookup, add, add unique, delete first, replace all and clear over a list
// held in one RAM and walked by a small sequencer.
// -----------------------------------------------------------------------------
// A request word carries an action and two values. The block walks the list
// one entry per cycle through a single RAM read port and a single comparator
// for lookup, add, add unique, delete and replace, and walks the entries
// behind the first match once more for a delete that has to close the gap;
// clear needs no walk. Replace overwrites matching entries during the same
// walk. The slave side is ready only while no request is in progress; one
// result word waits in an output register, so the next request is taken
// while the previous result is still unread.
// Entries at or above the current count are never read, so the RAM needs no
// clearing after reset.
`default_nettype none

module integer_list_table #(
	parameter int CAPACITY = ilt_pkg::CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request: [2:0] action, [34:3] value, [66:35] match_value, [71:67] zero
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,
	// result: [1:0] status, [2] found, [9:3] occurrences,
	//         [16:10] first_index, [23:17] entry_count
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata
);

	localparam int DW = ilt_pkg::DATA_W;
	localparam int AW = ilt_pkg::ACT_W;
	localparam int FW = ilt_pkg::FLD_W;
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = (CW > FW) ? CW : FW;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_POST  = 5'b00100,
		S_SHIFT = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t state_q;

	// request held for the whole walk
	logic [AW-1:0] act_q;
	logic [DW-1:0] val_q;
	logic [DW-1:0] key_q;

	logic [CW-1:0] used_q;
	logic [CW-1:0] rd_idx_q;
	logic          cmp_vld_s1;
	logic          last_s1;
	logic [IW-1:0] cmp_idx_s1;

	logic          hit_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] first_q;
	logic [ilt_pkg::STAT_W-1:0] status_q;

	// output register
	logic [ilt_pkg::STAT_W-1:0] o_status_q;
	logic          o_found_q;
	logic [FW-1:0] o_occ_q;
	logic [FW-1:0] o_first_q;
	logic [FW-1:0] o_count_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [DW-1:0] ram_rdata;

	logic [AW-1:0] in_act;
	logic [DW-1:0] in_val;
	logic [DW-1:0] in_mval;
	logic          accept;
	logic          match;
	logic          issue;
	logic          full;
	logic          do_append;
	logic          out_load;
	logic [SW-1:0] occ_ext;
	logic [SW-1:0] first_ext;
	logic [SW-1:0] used_ext;

	assign in_act  = s_axis_tdata[2:0];
	assign in_val  = s_axis_tdata[34:3];
	assign in_mval = s_axis_tdata[66:35];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign match     = (ram_rdata == key_q);
	assign issue     = (rd_idx_q < used_q);
	assign full      = (used_q == CW'(CAPACITY));
	assign do_append = !full && ((act_q == ilt_pkg::ACT_ADD) ||
		((act_q == ilt_pkg::ACT_ADD_UNIQ) && !hit_q));
	assign out_load  = (state_q == S_FIN) && (!m_axis_tvalid || m_axis_tready);

	// RAM port control: read ahead at rd_idx, write behind at the compare stage
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cmp_idx_s1;
		ram_wdata = val_q;
		ram_raddr = rd_idx_q[IW-1:0];
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = '0;
			end
			S_SCAN: begin
				// replace rewrites a matching entry as soon as it is compared
				ram_we = cmp_vld_s1 && match && (act_q == ilt_pkg::ACT_REPLACE);
			end
			S_POST: begin
				ram_we    = do_append;
				ram_waddr = used_q[IW-1:0];
			end
			S_SHIFT: begin
				// move entry j down to j - 1
				ram_we    = cmp_vld_s1;
				ram_waddr = cmp_idx_s1 - IW'(1);
				ram_wdata = ram_rdata;
			end
			S_FIN: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ilt_ram #(
		.WIDTH (DW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			last_s1    <= 1'b0;
			cmp_idx_s1 <= '0;
			hit_q      <= 1'b0;
			count_q    <= '0;
			first_q    <= '0;
			status_q   <= ilt_pkg::STAT_DONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						hit_q    <= 1'b0;
						count_q  <= '0;
						first_q  <= '0;
						status_q <= ilt_pkg::STAT_DONE;
						if (in_act == ilt_pkg::ACT_CLEAR) begin
							used_q  <= '0;
							state_q <= S_FIN;
						end else if (used_q == '0) begin
							state_q <= S_POST;
						end else begin
							// entry 0 is read this cycle
							cmp_vld_s1 <= 1'b1;
							cmp_idx_s1 <= '0;
							last_s1    <= (used_q == CW'(1));
							rd_idx_q   <= CW'(1);
							state_q    <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (cmp_vld_s1 && match) begin
						hit_q   <= 1'b1;
						count_q <= count_q + CW'(1);
						if (!hit_q) begin
							first_q <= cmp_idx_s1;
						end
					end
					cmp_vld_s1 <= issue;
					if (issue) begin
						cmp_idx_s1 <= rd_idx_q[IW-1:0];
						last_s1    <= (rd_idx_q == used_q - CW'(1));
						rd_idx_q   <= rd_idx_q + CW'(1);
					end
					if (cmp_vld_s1 && last_s1) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					state_q <= S_FIN;
					unique case (act_q)
						ilt_pkg::ACT_ADD_UNIQ, ilt_pkg::ACT_ADD: begin
							if (do_append) begin
								used_q <= used_q + CW'(1);
							end else if (full && ((act_q == ilt_pkg::ACT_ADD) || !hit_q)) begin
								status_q <= ilt_pkg::STAT_FULL;
							end
						end
						ilt_pkg::ACT_DELETE: begin
							if (!hit_q) begin
								status_q <= ilt_pkg::STAT_NOT_FOUND;
							end else if (CW'(first_q) + CW'(1) < used_q) begin
								rd_idx_q   <= CW'(first_q) + CW'(1);
								cmp_vld_s1 <= 1'b0;
								state_q    <= S_SHIFT;
							end else begin
								used_q <= used_q - CW'(1);
							end
						end
						default: begin
							// lookup, replace, and unused codes read as lookup
							if (!hit_q) begin
								status_q <= ilt_pkg::STAT_NOT_FOUND;
							end
						end
					endcase
				end
				S_SHIFT: begin
					cmp_vld_s1 <= issue;
					if (issue) begin
						cmp_idx_s1 <= rd_idx_q[IW-1:0];
						last_s1    <= (rd_idx_q == used_q - CW'(1));
						rd_idx_q   <= rd_idx_q + CW'(1);
					end
					if (cmp_vld_s1 && last_s1) begin
						used_q  <= used_q - CW'(1);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= in_act;
			val_q <= in_val;
			key_q <= (in_act == ilt_pkg::ACT_REPLACE) ? in_mval : in_val;
		end
	end

	// saturate the reported fields to seven bits (first_index to 63)
	assign occ_ext   = SW'(count_q);
	assign first_ext = SW'(first_q);
	assign used_ext  = SW'(used_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_status_q <= status_q;
			o_found_q  <= hit_q;
			o_occ_q    <= (occ_ext > SW'(127)) ? FW'(127) : occ_ext[FW-1:0];
			o_first_q  <= !hit_q ? ilt_pkg::IDX_NONE :
				((first_ext > SW'(63)) ? FW'(63) : first_ext[FW-1:0]);
			o_count_q  <= (used_ext > SW'(127)) ? FW'(127) : used_ext[FW-1:0];
		end
	end

	assign m_axis_tdata = {o_count_q, o_first_q, o_occ_q, o_found_q, o_status_q};

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_read_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmp_vld_s1 && (state_q == S_SCAN || state_q == S_SHIFT)) |->
		(CW'(cmp_idx_s1) < used_q))
		else $error("walk read at or above entry count");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_act == ilt_pkg::ACT_CLEAR) |=> (used_q == '0))
		else $error("clear left entries");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POST || state_q == S_FIN) |-> (hit_q == (count_q != '0)))
		else $error("found flag disagrees with occurrence count");

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench - self-checking bench for the integer list table
// Walks a short table of hand-picked requests, then random request segments
// that grow, churn and shrink the list, with both stream sides idling.
// -----------------------------------------------------------------------------
// Every request word the block takes is run through a local copy of the list
// right away; the reply it should produce is queued and compared field by
// field with the next reply word that leaves the block. Rows of the opening
// table whose reply is obvious carry that reply typed in; the rest, and all
// random requests, rely on the local copy.
`default_nettype none

module testbench;

	localparam int LIST_DEPTH   = ilt_pkg::CAPACITY_DEF;
	localparam int TOTAL_ITEMS  = 1450;
	localparam int SEG_LEN      = 40;
	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 200;   // margin for the worst delete walk
	localparam int IDLE_LIMIT   = 3000;  // cycles with no word moving either way
	localparam int PRINT_LIMIT  = 200;

	// action codes outside the named set; the block treats them as lookup
	localparam logic [ilt_pkg::ACT_W-1:0] ACT_SPARE_6 = 3'd6;
	localparam logic [ilt_pkg::ACT_W-1:0] ACT_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [ilt_pkg::FLD_W-1:0]  entry_count;
		logic [ilt_pkg::FLD_W-1:0]  first_index;
		logic [ilt_pkg::FLD_W-1:0]  occurrences;
		logic                       found;
		logic [ilt_pkg::STAT_W-1:0] status;
	} list_reply_t;

	typedef struct {
		logic [ilt_pkg::ACT_W-1:0]  act;
		logic [ilt_pkg::DATA_W-1:0] val;
		logic [ilt_pkg::DATA_W-1:0] mval;
		bit                         typed;
		list_reply_t                reply;
	} opening_row_t;

	typedef enum {SEG_FILL, SEG_BALANCED, SEG_SHRINK} seg_mode_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;

	// local copy of the list
	logic [ilt_pkg::DATA_W-1:0] list_mem [LIST_DEPTH];
	int                         list_len = 0;
	int                         peak_len = 0;

	list_reply_t pending_replies [$];
	logic [ilt_pkg::DATA_W-1:0] value_pool [12];
	opening_row_t opening_rows [18];

	int  requests_sent   = 0;
	int  replies_checked = 0;
	int  mismatch_count  = 0;
	int  refused_appends = 0;
	int  misses          = 0;
	int  idle_cycles     = 0;
	bit  quiet           = 1'b0;  // no random idling on either side while set
	bit  sink_hold_req   = 1'b0;

	integer_list_table u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one request to the local list and return the reply it must give.
	function automatic list_reply_t step_list(input logic [ilt_pkg::ACT_W-1:0] act,
			input logic [ilt_pkg::DATA_W-1:0] val, input logic [ilt_pkg::DATA_W-1:0] mval);
		logic [ilt_pkg::DATA_W-1:0] key;
		int hits;
		int first;
		int i;
		list_reply_t r;
		key = (act == ilt_pkg::ACT_REPLACE) ? mval : val;
		hits = 0;
		first = -1;
		for (i = 0; i < list_len; i++) begin
			if (list_mem[i] == key) begin
				if (hits == 0)
					first = i;
				hits++;
			end
		end
		r.status = ilt_pkg::STAT_DONE;
		case (act)
			ilt_pkg::ACT_ADD_UNIQ: begin
				if (hits == 0) begin
					if (list_len >= LIST_DEPTH) begin
						r.status = ilt_pkg::STAT_FULL;
					end else begin
						list_mem[list_len] = val;
						list_len++;
					end
				end
			end
			ilt_pkg::ACT_ADD: begin
				if (list_len >= LIST_DEPTH) begin
					r.status = ilt_pkg::STAT_FULL;
				end else begin
					list_mem[list_len] = val;
					list_len++;
				end
			end
			ilt_pkg::ACT_DELETE: begin
				if (hits != 0) begin
					// close the gap left by the first match
					for (i = first; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
				end else begin
					r.status = ilt_pkg::STAT_NOT_FOUND;
				end
			end
			ilt_pkg::ACT_REPLACE: begin
				if (hits != 0) begin
					for (i = 0; i < list_len; i++)
						if (list_mem[i] == mval)
							list_mem[i] = val;
				end else begin
					r.status = ilt_pkg::STAT_NOT_FOUND;
				end
			end
			ilt_pkg::ACT_CLEAR: begin
				list_len = 0;
				hits = 0;
				first = -1;
			end
			default: begin
				// lookup and the two spare codes
				if (hits == 0)
					r.status = ilt_pkg::STAT_NOT_FOUND;
			end
		endcase
		r.found = (hits != 0);
		r.occurrences = hits[ilt_pkg::FLD_W-1:0];
		r.first_index = (hits != 0) ? first[ilt_pkg::FLD_W-1:0] : ilt_pkg::IDX_NONE;
		r.entry_count = list_len[ilt_pkg::FLD_W-1:0];
		return r;
	endfunction

	function automatic opening_row_t mk_row(input logic [ilt_pkg::ACT_W-1:0] act,
			input logic [ilt_pkg::DATA_W-1:0] val, input logic [ilt_pkg::DATA_W-1:0] mval,
			input bit typed, input logic [ilt_pkg::STAT_W-1:0] status, input logic found,
			input int occ, input logic [ilt_pkg::FLD_W-1:0] idx, input int cnt);
		opening_row_t row;
		row.act = act;
		row.val = val;
		row.mval = mval;
		row.typed = typed;
		row.reply.status = status;
		row.reply.found = found;
		row.reply.occurrences = occ[ilt_pkg::FLD_W-1:0];
		row.reply.first_index = idx;
		row.reply.entry_count = cnt[ilt_pkg::FLD_W-1:0];
		return row;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ilt_pkg::DATA_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 75)
			return value_pool[$urandom_range(0, 11)];
		return $urandom();
	endfunction

	// Favor values already held so searches hit.
	function automatic logic [ilt_pkg::DATA_W-1:0] pick_key();
		if (list_len > 0 && $urandom_range(0, 1) == 1)
			return list_mem[$urandom_range(0, list_len - 1)];
		return pick_value();
	endfunction

	// Offer one request word, hold it until taken, then queue its reply.
	task automatic send_request(input logic [ilt_pkg::ACT_W-1:0] act,
			input logic [ilt_pkg::DATA_W-1:0] val, input logic [ilt_pkg::DATA_W-1:0] mval,
			input bit typed, input list_reply_t typed_reply);
		list_reply_t r;
		int gap;
		if (!quiet && $urandom_range(0, 99) < 35) begin
			gap = pick_gap();
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, mval, val, act};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		r = step_list(act, val, mval);
		if (typed)
			r = typed_reply;
		pending_replies.push_back(r);
		requests_sent++;
		if (r.status == ilt_pkg::STAT_FULL)
			refused_appends++;
		if (r.status == ilt_pkg::STAT_NOT_FOUND)
			misses++;
		if (list_len > peak_len)
			peak_len = list_len;
	endtask

	task automatic random_request(input seg_mode_t mode);
		int r;
		logic [ilt_pkg::ACT_W-1:0] act;
		logic [ilt_pkg::DATA_W-1:0] val;
		logic [ilt_pkg::DATA_W-1:0] mval;
		r = $urandom_range(0, 99);
		case (mode)
			SEG_FILL: begin
				act = (r < 70) ? ilt_pkg::ACT_ADD : (r < 88) ? ilt_pkg::ACT_ADD_UNIQ :
					(r < 95) ? ilt_pkg::ACT_LOOKUP : ilt_pkg::ACT_REPLACE;
			end
			SEG_SHRINK: begin
				act = (r < 50) ? ilt_pkg::ACT_DELETE : (r < 65) ? ilt_pkg::ACT_REPLACE :
					(r < 85) ? ilt_pkg::ACT_LOOKUP : (r < 97) ? ilt_pkg::ACT_ADD :
					ilt_pkg::ACT_CLEAR;
			end
			default: begin
				act = (r < 18) ? ilt_pkg::ACT_LOOKUP : (r < 33) ? ilt_pkg::ACT_ADD_UNIQ :
					(r < 55) ? ilt_pkg::ACT_ADD : (r < 72) ? ilt_pkg::ACT_DELETE :
					(r < 88) ? ilt_pkg::ACT_REPLACE : (r < 91) ? ilt_pkg::ACT_CLEAR :
					(r < 93) ? ACT_SPARE_6 : (r < 95) ? ACT_SPARE_7 : ilt_pkg::ACT_ADD;
			end
		endcase
		// the operand the action ignores still carries random noise
		val = (act == ilt_pkg::ACT_REPLACE) ? pick_value() : pick_key();
		mval = (act == ilt_pkg::ACT_REPLACE) ? pick_key() : pick_value();
		send_request(act, val, mval, 1'b0, '0);
	endtask

	// Drop valid and hold until every queued reply has come back.
	task automatic drain_replies();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// Request side: opening table, then random segments, then wrap up.
	initial begin : request_source
		int i;
		int seg;
		seg_mode_t mode;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		value_pool[2] = 32'h8000_0000;
		value_pool[3] = 32'h7FFF_FFFF;
		for (i = 4; i < 12; i++)
			value_pool[i] = $urandom();

		// empty-list misses, the value extremes, duplicates, spare codes, clear
		opening_rows[0]  = mk_row(ilt_pkg::ACT_LOOKUP, 32'h0, 32'h0, 1,
			ilt_pkg::STAT_NOT_FOUND, 0, 0, ilt_pkg::IDX_NONE, 0);
		opening_rows[1]  = mk_row(ilt_pkg::ACT_DELETE, 32'h5, 32'h0, 1,
			ilt_pkg::STAT_NOT_FOUND, 0, 0, ilt_pkg::IDX_NONE, 0);
		opening_rows[2]  = mk_row(ilt_pkg::ACT_REPLACE, 32'h7, 32'h5, 1,
			ilt_pkg::STAT_NOT_FOUND, 0, 0, ilt_pkg::IDX_NONE, 0);
		opening_rows[3]  = mk_row(ilt_pkg::ACT_ADD_UNIQ, 32'h8000_0000, 32'hFFFF_FFFF, 1,
			ilt_pkg::STAT_DONE, 0, 0, ilt_pkg::IDX_NONE, 1);
		opening_rows[4]  = mk_row(ilt_pkg::ACT_ADD, 32'h7FFF_FFFF, 32'h0, 1,
			ilt_pkg::STAT_DONE, 0, 0, ilt_pkg::IDX_NONE, 2);
		opening_rows[5]  = mk_row(ilt_pkg::ACT_ADD_UNIQ, 32'h7FFF_FFFF, 32'h0, 1,
			ilt_pkg::STAT_DONE, 1, 1, 7'd1, 2);
		opening_rows[6]  = mk_row(ilt_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'h0, 1,
			ilt_pkg::STAT_DONE, 0, 0, ilt_pkg::IDX_NONE, 3);
		opening_rows[7]  = mk_row(ilt_pkg::ACT_ADD, 32'h8000_0000, 32'h0, 1,
			ilt_pkg::STAT_DONE, 1, 1, 7'd0, 4);
		opening_rows[8]  = mk_row(ilt_pkg::ACT_LOOKUP, 32'h8000_0000, 32'h0, 1,
			ilt_pkg::STAT_DONE, 1, 2, 7'd0, 4);
		opening_rows[9]  = mk_row(ilt_pkg::ACT_REPLACE, 32'h0, 32'h8000_0000, 1,
			ilt_pkg::STAT_DONE, 1, 2, 7'd0, 4);
		opening_rows[10] = mk_row(ilt_pkg::ACT_DELETE, 32'h0, 32'h0, 0,
			ilt_pkg::STAT_DONE, 0, 0, ilt_pkg::IDX_NONE, 0);
		opening_rows[11] = mk_row(ACT_SPARE_6, 32'hFFFF_FFFF, 32'h0, 0,
			ilt_pkg::STAT_DONE, 0, 0, ilt_pkg::IDX_NONE, 0);
		opening_rows[12] = mk_row(ACT_SPARE_7, 32'h0001_2345, 32'h0, 0,
			ilt_pkg::STAT_DONE, 0, 0, ilt_pkg::IDX_NONE, 0);
		opening_rows[13] = mk_row(ilt_pkg::ACT_ADD_UNIQ, 32'h0, 32'h0, 0,
			ilt_pkg::STAT_DONE, 0, 0, ilt_pkg::IDX_NONE, 0);
		opening_rows[14] = mk_row(ilt_pkg::ACT_DELETE, 32'h7FFF_FFFF, 32'h0, 0,
			ilt_pkg::STAT_DONE, 0, 0, ilt_pkg::IDX_NONE, 0);
		opening_rows[15] = mk_row(ilt_pkg::ACT_REPLACE, 32'h5555_5555, 32'hAAAA_AAAA, 1,
			ilt_pkg::STAT_NOT_FOUND, 0, 0, ilt_pkg::IDX_NONE, 2);
		opening_rows[16] = mk_row(ilt_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'h0, 1,
			ilt_pkg::STAT_DONE, 0, 0, ilt_pkg::IDX_NONE, 0);
		opening_rows[17] = mk_row(ilt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1,
			ilt_pkg::STAT_NOT_FOUND, 0, 0, ilt_pkg::IDX_NONE, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[i])
			send_request(opening_rows[i].act, opening_rows[i].val, opening_rows[i].mval,
				opening_rows[i].typed, opening_rows[i].reply);
		drain_replies();

		// two fill segments in every six push the list to full and past it
		seg = 0;
		while (requests_sent < TOTAL_ITEMS) begin
			quiet = ($urandom_range(0, 4) == 0);
			if (seg % 6 < 2)
				mode = SEG_FILL;
			else
				mode = ($urandom_range(0, 2) == 0) ? SEG_SHRINK : SEG_BALANCED;
			if (seg == 6)
				sink_hold_req = 1'b1;
			if (seg == 14)
				drain_replies();
			for (i = 0; i < SEG_LEN && requests_sent < TOTAL_ITEMS; i++)
				random_request(mode);
			seg++;
		end

		drain_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests and checked %0d replies; list peaked at %0d entries,",
			requests_sent, replies_checked, peak_len);
		$display("%0d appends refused on a full list, %0d searches missed.",
			refused_appends, misses);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Reply side: random back-pressure, plus one long hold-off on request.
	initial begin : reply_sink
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				gap = pick_gap();
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			// keep the log short once the block is clearly broken
			if (mismatch_count <= PRINT_LIMIT)
				$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Compare every reply word taken against the oldest queued reply.
	always @(posedge clk) begin
		list_reply_t got;
		list_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = list_reply_t'(m_axis_tdata);
			if (pending_replies.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: unexpected reply word, expected none, got %0h",
					$time, m_axis_tdata);
			end else begin
				want = pending_replies.pop_front();
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("found", 32'(want.found), 32'(got.found));
				check_field("occurrences", 32'(want.occurrences), 32'(got.occurrences));
				check_field("first_index", 32'(want.first_index), 32'(got.first_index));
				check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
				replies_checked++;
			end
		end
	end

	// Watchdog: give up when no word has moved on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t ns: no word moved for %0d cycles, %0d replies outstanding",
					$time, IDLE_LIMIT, pending_replies.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule

`default_nettype wire
